/* hdl/hipd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hipd_pkg
// Shared types, codes and constants of the HCI inbound packet deframer.
// ----------------------------------------------------------------------------
package hipd_pkg;

    localparam int CHANNELS_DEFAULT   = 3;
    localparam int HEADER_MAX_DEFAULT = 4;

    localparam logic [1:0] CH_ACL     = 2'd0;
    localparam logic [1:0] CH_SCO     = 2'd1;
    localparam logic [1:0] CH_EVENT   = 2'd2;
    localparam logic [1:0] CH_INVALID = 2'd3;

    localparam logic [2:0] ACL_PREAMBLE_BYTES   = 3'd4;
    localparam logic [2:0] SCO_PREAMBLE_BYTES   = 3'd3;
    localparam logic [2:0] EVENT_PREAMBLE_BYTES = 3'd2;

    localparam logic [7:0] EVT_CODE_CMD_COMPLETE = 8'h0E;
    localparam logic [7:0] EVT_CODE_CMD_STATUS   = 8'h0F;

    localparam logic [1:0] FLOW_NONE         = 2'd0;
    localparam logic [1:0] FLOW_CMD_COMPLETE = 2'd1;
    localparam logic [1:0] FLOW_CMD_STATUS   = 2'd2;

    localparam logic [15:0] MAX_BODY_LENGTH_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PREAMBLE,
        PH_BODY,
        PH_IGNORE
    } hipd_phase_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  out_channel;
        logic        packet_start;
        logic        in_header;
        logic        packet_end;
        logic        dropped;
        logic [15:0] body_length;
        logic [1:0]  flow_event;
        logic [7:0]  new_credits;
        logic [15:0] cmd_opcode;
        logic [7:0]  cmd_status;
    } hipd_result_t;

    function automatic logic [2:0] pre_size(input logic [1:0] ch);
        logic [2:0] size;
        unique case (ch)
            CH_ACL:   size = ACL_PREAMBLE_BYTES;
            CH_SCO:   size = SCO_PREAMBLE_BYTES;
            default:  size = EVENT_PREAMBLE_BYTES;
        endcase
        return size;
    endfunction

endpackage
`default_nettype wire

/* hdl/hipd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hipd_if
// Request channels of the deframer: received bytes, framed bytes and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface hipd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] channel;
    logic [7:0] rx_byte;

    modport source (output valid, output channel, output rx_byte, input ready);
    modport sink (input valid, input channel, input rx_byte, output ready);
endinterface

interface hipd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  out_channel;
    logic        packet_start;
    logic        in_header;
    logic        packet_end;
    logic        dropped;
    logic [15:0] body_length;
    logic [1:0]  flow_event;
    logic [7:0]  new_credits;
    logic [15:0] cmd_opcode;
    logic [7:0]  cmd_status;

    modport source (
        output valid, output out_byte, output out_channel, output packet_start,
        output in_header, output packet_end, output dropped, output body_length,
        output flow_event, output new_credits, output cmd_opcode, output cmd_status,
        input ready
    );
    modport sink (
        input valid, input out_byte, input out_channel, input packet_start,
        input in_header, input packet_end, input dropped, input body_length,
        input flow_event, input new_credits, input cmd_opcode, input cmd_status,
        output ready
    );
endinterface

interface hipd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/hci_inbound_packet_deframer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hci_inbound_packet_deframer_top
// HCI inbound packet deframer: per-channel preamble, length and body framing
// of received bytes with flow event reporting.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the output side is ready and returns
// one framed byte for each, in order, through the state stage and the output register.
// The rate is set by the per-channel state memory: each byte reads its channel's entry
// when it is taken and writes it back as it leaves the state stage, and a write-first
// read path lets a byte of the same channel follow directly. The state needs no
// clearing pass after reset. The length limit may be written at any idle time.
module hci_inbound_packet_deframer_top #(
    parameter int CHANNELS   = hipd_pkg::CHANNELS_DEFAULT,
    parameter int HEADER_MAX = hipd_pkg::HEADER_MAX_DEFAULT
) (
    input wire logic   clk,
    input wire logic   rst_n,
    hipd_in_if.sink    rx,
    hipd_out_if.source tx,
    hipd_cfg_if.sink   cfg
);
    import hipd_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EW = 34 + 8 * HEADER_MAX;

    logic          accept;
    logic          chan_ok;
    logic [AW-1:0] raddr;
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_adv;
    logic          s1_ok_reg;
    logic [1:0]    s1_chan_reg;
    logic [7:0]    s1_byte_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [EW-1:0] entry;
    logic [EW-1:0] entry_next;
    logic          mem_we;
    hipd_result_t  res;
    hipd_result_t  tx_data_reg;
    logic          tx_valid_reg, tx_valid_next;
    logic [15:0]   max_len_reg;

    assign chan_ok = (rx.channel != CH_INVALID) && ({30'd0, rx.channel} < 32'(CHANNELS));
    assign raddr   = chan_ok ? rx.channel[AW-1:0] : '0;

    assign s1_adv   = s1_valid_reg && (!tx_valid_reg || tx.ready);
    assign rx.ready = !s1_valid_reg || s1_adv;
    assign accept   = rx.valid && rx.ready;
    assign mem_we   = s1_adv && s1_ok_reg;

    assign s1_valid_next = accept || (s1_valid_reg && !s1_adv);
    assign tx_valid_next = s1_adv || (tx_valid_reg && !tx.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            tx_valid_reg <= 1'b0;
            max_len_reg  <= MAX_BODY_LENGTH_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            tx_valid_reg <= tx_valid_next;
            if (cfg.valid)
            begin
                max_len_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg   <= chan_ok;
            s1_chan_reg <= rx.channel;
            s1_byte_reg <= rx.rx_byte;
            s1_addr_reg <= raddr;
        end
        if (s1_adv)
        begin
            tx_data_reg <= res;
        end
    end

    hipd_state_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW),
        .WIDTH (EW)
    ) u_state_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (accept),
        .raddr (raddr),
        .we    (mem_we),
        .waddr (s1_addr_reg),
        .wdata (entry_next),
        .rdata (entry)
    );

    hipd_frame_update #(
        .HEADER_MAX (HEADER_MAX),
        .EW         (EW)
    ) u_frame_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (s1_adv),
        .chan_ok    (s1_ok_reg),
        .chan       (s1_chan_reg),
        .rx_byte    (s1_byte_reg),
        .max_len    (max_len_reg),
        .entry      (entry),
        .entry_next (entry_next),
        .res        (res)
    );

    assign cfg.ready       = 1'b1;
    assign tx.valid        = tx_valid_reg;
    assign tx.out_byte     = tx_data_reg.out_byte;
    assign tx.out_channel  = tx_data_reg.out_channel;
    assign tx.packet_start = tx_data_reg.packet_start;
    assign tx.in_header    = tx_data_reg.in_header;
    assign tx.packet_end   = tx_data_reg.packet_end;
    assign tx.dropped      = tx_data_reg.dropped;
    assign tx.body_length  = tx_data_reg.body_length;
    assign tx.flow_event   = tx_data_reg.flow_event;
    assign tx.new_credits  = tx_data_reg.new_credits;
    assign tx.cmd_opcode   = tx_data_reg.cmd_opcode;
    assign tx.cmd_status   = tx_data_reg.cmd_status;

    // A request held in the state stage keeps its byte and channel until it moves on.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=>
            (s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_chan_reg)))
        else $error("state stage lost a stalled request");

    a_start_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.packet_start) |-> (tx.in_header && !tx.dropped))
        else $error("packet start outside the preamble");

    a_flow_at_event_end: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.flow_event != FLOW_NONE) |->
            (tx.packet_end && tx.out_channel == CH_EVENT && !tx.dropped))
        else $error("flow event away from the end of an event packet");

endmodule
`default_nettype wire

/* hdl/hipd_state_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hipd_state_mem
// Per-channel framing state memory with registered, write-first read and
// per-entry valid bits; an entry never written reads as all zeros.
// ----------------------------------------------------------------------------
module hipd_state_mem #(
    parameter int DEPTH = 3,
    parameter int AW    = 2,
    parameter int WIDTH = 66
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic             fwd;

    assign fwd = we && (waddr == raddr);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= fwd ? wdata : mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= fwd ? 1'b1 : valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

/* hdl/hipd_frame_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hipd_frame_update
// Read-modify-write step of one channel's framing state, the event body
// capture and the marks and fields of the framed byte.
// ----------------------------------------------------------------------------
module hipd_frame_update #(
    parameter int HEADER_MAX = 4,
    parameter int EW         = 34 + 8 * HEADER_MAX
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                commit,
    input  wire logic                chan_ok,
    input  wire logic [1:0]          chan,
    input  wire logic [7:0]          rx_byte,
    input  wire logic [15:0]         max_len,
    input  wire logic [EW-1:0]       entry,
    output logic      [EW-1:0]       entry_next,
    output hipd_pkg::hipd_result_t   res
);
    import hipd_pkg::*;

    localparam int HW = $clog2(HEADER_MAX);

    typedef logic [HEADER_MAX-1:0][7:0] hdr_t;

    function automatic logic [7:0] hbyte(input hdr_t h, input logic [15:0] i);
        return (i < 16'(HEADER_MAX)) ? h[i[HW-1:0]] : 8'h00;
    endfunction

    function automatic logic [15:0] decl_len(input logic [1:0] ch, input hdr_t h);
        logic [15:0] len;
        if (ch == CH_ACL)
        begin
            len = {hbyte(h, 16'd3), hbyte(h, 16'd2)};
        end
        else
        begin
            len = {8'h00, hbyte(h, {13'd0, pre_size(ch)} - 16'd1)};
        end
        return len;
    endfunction

    hipd_phase_t      ph_old, ph0, ph_n;
    logic [15:0]      rem_old, rem0, rem_n;
    logic [15:0]      idx_old, idx0, idx_n;
    hdr_t             hdr_old, hdr0, hdr_n;
    logic [4:0][7:0]  ev_reg, ev_next;
    logic [15:0]      len;
    logic [15:0]      k;
    logic             finished;

    assign ph_old  = hipd_phase_t'(entry[EW-1 -: 2]);
    assign rem_old = entry[EW-3 -: 16];
    assign idx_old = entry[EW-19 -: 16];
    assign hdr_old = hdr_t'(entry[8*HEADER_MAX-1:0]);

    always_comb
    begin
        res             = '0;
        res.out_byte    = rx_byte;
        res.out_channel = chan;
        ph0      = ph_old;
        rem0     = rem_old;
        idx0     = idx_old;
        hdr0     = hdr_old;
        ev_next  = ev_reg;
        len      = 16'd0;
        k        = 16'd0;
        finished = 1'b0;
        if (chan_ok && ph_old == PH_IDLE)
        begin
            res.packet_start = 1'b1;
            ph0  = PH_PREAMBLE;
            rem0 = {13'd0, pre_size(chan)};
            idx0 = 16'd0;
            hdr0 = '0;
            if (chan == CH_EVENT)
            begin
                ev_next = '0;
            end
        end
        ph_n  = ph0;
        rem_n = rem0 - 16'd1;
        idx_n = idx0 + 16'd1;
        hdr_n = hdr0;
        if (!chan_ok)
        begin
            res.dropped = 1'b1;
        end
        else
        begin
            unique case (ph0)
                PH_PREAMBLE:
                begin
                    res.in_header = 1'b1;
                    if (idx0 < 16'(HEADER_MAX))
                    begin
                        hdr_n[idx0[HW-1:0]] = rx_byte;
                    end
                    if (rem_n == 16'd0)
                    begin
                        len = (chan == CH_ACL) ? decl_len(chan, hdr_n) : {8'h00, rx_byte};
                        res.body_length = len;
                        rem_n = len;
                        if (len > max_len)
                        begin
                            ph_n = PH_IGNORE;
                        end
                        else if (len == 16'd0)
                        begin
                            finished = 1'b1;
                        end
                        else
                        begin
                            ph_n = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    k = idx0 - {13'd0, pre_size(chan)};
                    res.body_length = decl_len(chan, hdr0);
                    if (chan == CH_EVENT && k < 16'd5)
                    begin
                        ev_next[k[2:0]] = rx_byte;
                    end
                    if (rem_n == 16'd0)
                    begin
                        finished = 1'b1;
                    end
                end
                default:
                begin
                    res.dropped = 1'b1;
                    res.body_length = decl_len(chan, hdr0);
                    if (rem_n == 16'd0)
                    begin
                        res.packet_end = 1'b1;
                        ph_n = PH_IDLE;
                    end
                end
            endcase
            if (finished)
            begin
                res.packet_end = 1'b1;
                ph_n = PH_IDLE;
                if (chan == CH_EVENT)
                begin
                    if (hdr_n[0] == EVT_CODE_CMD_COMPLETE)
                    begin
                        res.flow_event  = FLOW_CMD_COMPLETE;
                        res.new_credits = ev_next[0];
                        res.cmd_opcode  = {ev_next[2], ev_next[1]};
                    end
                    else if (hdr_n[0] == EVT_CODE_CMD_STATUS)
                    begin
                        res.flow_event  = FLOW_CMD_STATUS;
                        res.new_credits = ev_next[1];
                        res.cmd_opcode  = {ev_next[3], ev_next[2]};
                        res.cmd_status  = ev_next[0];
                    end
                end
            end
        end
    end

    assign entry_next = {ph_n, rem_n, idx_n, hdr_n};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= '0;
        end
        else if (commit && chan_ok)
        begin
            ev_reg <= ev_next;
        end
    end

endmodule
`default_nettype wire
